// ----- design/mebe_pkg.sv -----
// shared types, sizes and register codes of the misfire emission block evaluator
package mebe_pkg;

    localparam int CYLINDERS = 4;
    localparam int LANES     = 4;
    localparam int FITTED    = (CYLINDERS > LANES) ? LANES : CYLINDERS;

    localparam int CNT_W     = 16;
    localparam int SUM_W     = CNT_W + $clog2(LANES);
    localparam int PROD_W    = 2 * CNT_W;
    localparam int RATE_W    = 8;
    localparam int PERMIL_W  = 10;
    localparam int CFG_IDX_W = 2;

    // one quotient bit per divider stage
    localparam int DIV_STEPS = RATE_W;
    // accept to result strobe, in cycles
    localparam int LAT       = 4 + DIV_STEPS;
    // flag registers from the blame merge to the output
    localparam int FLAG_DLY  = LAT - 4;

    localparam logic [CNT_W-1:0]     SUM_MAX        = '1;
    localparam logic [RATE_W-1:0]    RATE_MAX       = '1;
    localparam logic [CNT_W-1:0]     MIN_SUM_RST    = 16'd0;
    localparam logic [CNT_W-1:0]     SHARE_RST      = 16'd32768;
    localparam logic [CNT_W-1:0]     FIRINGS_RST    = 16'd2000;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SUM    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRINGS    = 2'd2;

    typedef logic [CNT_W-1:0] t_count;

    // control from the merge stage to every lane
    typedef struct packed {
        logic              fault;
        logic [PROD_W-1:0] prod;
    } t_lane_ctl;

    typedef struct packed {
        logic [CNT_W-1:0] sum;
        logic             fault;
        logic [LANES-1:0] blame;
        logic             none;
    } t_flags;

    typedef struct packed {
        logic [CNT_W-1:0]  rem;
        logic [RATE_W-1:0] quo;
        logic              sat;
    } t_div;

endpackage

// ----- design/mebe_lane.sv -----
// one cylinder lane: cut masking and the share test against the scaled sum
module mebe_lane
    import mebe_pkg::*;
(
    input  logic      i_clk,
    input  t_count    i_count,
    input  logic      i_cut,
    input  logic      i_fitted,
    input  t_lane_ctl i_ctl,
    output t_count    o_count,
    output logic      o_blame
);

    t_count r_cnt_s1;
    t_count r_cnt_s2;
    t_count r_cnt_s3;
    logic   r_blame;
    logic   n_blame;

    always_comb begin
        n_blame = i_ctl.fault && i_fitted && ({r_cnt_s3, {CNT_W{1'b0}}} >= i_ctl.prod);
    end

    always_ff @(posedge i_clk) begin
        r_cnt_s1 <= (i_fitted && !i_cut) ? i_count : '0;
        r_cnt_s2 <= r_cnt_s1;
        r_cnt_s3 <= r_cnt_s2;
        r_blame  <= n_blame;
    end

    assign o_count = r_cnt_s1;
    assign o_blame = r_blame;

endmodule

// ----- design/mebe_merge.sv -----
// merge stage: saturated sum, fault test, share product and blame summary
module mebe_merge
    import mebe_pkg::*;
(
    input  logic             i_clk,
    input  t_count           i_count [LANES],
    input  logic [LANES-1:0] i_blame,
    input  t_count           i_min_sum,
    input  t_count           i_share,
    output t_count           o_sum_s2,
    output t_lane_ctl        o_ctl,
    output t_flags           o_flags
);

    logic [SUM_W-1:0]  n_total;
    t_count            n_sum;
    t_count            r_sum_s2;
    logic              r_fault_s2;
    t_count            r_sum_s3;
    logic              r_fault_s3;
    logic [PROD_W-1:0] r_prod_s3;
    t_count            r_sum_s4;
    logic              r_fault_s4;
    t_flags            r_flags [FLAG_DLY];
    t_flags            n_flags;

    always_comb begin
        n_total = '0;
        for (int i = 0; i < LANES; i++) begin
            n_total = n_total + SUM_W'(i_count[i]);
        end
        n_sum = (n_total > SUM_W'(SUM_MAX)) ? SUM_MAX : n_total[CNT_W-1:0];
    end

    always_comb begin
        n_flags.sum   = r_sum_s4;
        n_flags.fault = r_fault_s4;
        n_flags.blame = i_blame;
        n_flags.none  = r_fault_s4 && (i_blame == '0);
    end

    always_ff @(posedge i_clk) begin
        r_sum_s2   <= n_sum;
        r_fault_s2 <= n_sum > i_min_sum;
        r_sum_s3   <= r_sum_s2;
        r_fault_s3 <= r_fault_s2;
        r_prod_s3  <= PROD_W'(i_share) * PROD_W'(r_sum_s2);
        r_sum_s4   <= r_sum_s3;
        r_fault_s4 <= r_fault_s3;
        r_flags[0] <= n_flags;
        for (int k = 1; k < FLAG_DLY; k++) begin
            r_flags[k] <= r_flags[k-1];
        end
    end

    assign o_sum_s2   = r_sum_s2;
    assign o_ctl.fault = r_fault_s3;
    assign o_ctl.prod  = r_prod_s3;
    assign o_flags    = r_flags[FLAG_DLY-1];

endmodule

// ----- design/mebe_rate.sv -----
// pipelined restoring divider for the misfire rate, then the per-mille scaling
module mebe_rate
    import mebe_pkg::*;
(
    input  logic                i_clk,
    input  t_count              i_sum,
    input  t_count              i_firings,
    output logic [RATE_W-1:0]   o_rate,
    output logic [PERMIL_W-1:0] o_permille
);

    localparam int PM_W = RATE_W + PERMIL_W;

    t_div                r_div [DIV_STEPS+1];
    logic [RATE_W-1:0]   n_rate;
    logic [PM_W-1:0]     n_pm;
    logic [RATE_W-1:0]   r_rate;
    logic [PERMIL_W-1:0] r_permille;

    // quotient of sum*256 reaches 256 exactly when sum >= firings, zero firings included
    always_ff @(posedge i_clk) begin
        r_div[0].rem <= i_sum;
        r_div[0].quo <= '0;
        r_div[0].sat <= i_sum >= i_firings;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [CNT_W:0] rem2;
        logic           ge;

        always_comb begin
            rem2 = {r_div[k].rem, 1'b0};
            ge   = rem2 >= {1'b0, i_firings};
        end

        always_ff @(posedge i_clk) begin
            r_div[k+1].rem <= ge ? CNT_W'(rem2 - {1'b0, i_firings}) : rem2[CNT_W-1:0];
            r_div[k+1].quo <= {r_div[k].quo[RATE_W-2:0], ge};
            r_div[k+1].sat <= r_div[k].sat;
        end
    end

    always_comb begin
        n_rate = r_div[DIV_STEPS].sat ? RATE_MAX : r_div[DIV_STEPS].quo;
        n_pm   = PM_W'(n_rate) * PM_W'(1000) + PM_W'(128);
    end

    always_ff @(posedge i_clk) begin
        r_rate     <= n_rate;
        r_permille <= n_pm[PM_W-1:RATE_W];
    end

    assign o_rate     = r_rate;
    assign o_permille = r_permille;

endmodule

// ----- design/misfire_emission_block_evaluator.sv -----
// top level of the misfire emission block evaluator
//
// channel   | signals                                      | direction | handshake
// ----------+----------------------------------------------+-----------+-------------------
// item in   | i_count_cyl0..3, i_cut_mask                  | in        | i_start, o_busy
// result    | o_misfire_sum, o_fault_detected, o_blame_*,  | out       | o_done strobe
//           | o_misfire_rate, o_rate_permille              |           |
// config    | i_cfg_idx, i_cfg_data                        | in        | i_cfg_we
//
// one item per cycle; the misfire rate of each result is formed by the
// 8-stage restoring divider, one bit per stage
// o_busy stays low, so an item can be started in every cycle
// synchronous active-low reset clears the strobe pipeline and loads register defaults
// results are shown for one cycle and cannot be stalled
module misfire_emission_block_evaluator
    import mebe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [CNT_W-1:0]     i_count_cyl0,
    input  logic [CNT_W-1:0]     i_count_cyl1,
    input  logic [CNT_W-1:0]     i_count_cyl2,
    input  logic [CNT_W-1:0]     i_count_cyl3,
    input  logic [LANES-1:0]     i_cut_mask,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_data,
    output logic                 o_done,
    output logic [CNT_W-1:0]     o_misfire_sum,
    output logic                 o_fault_detected,
    output logic                 o_blame_cyl0,
    output logic                 o_blame_cyl1,
    output logic                 o_blame_cyl2,
    output logic                 o_blame_cyl3,
    output logic                 o_blame_none,
    output logic [RATE_W-1:0]    o_misfire_rate,
    output logic [PERMIL_W-1:0]  o_rate_permille
);

    t_count           r_min_sum;
    t_count           r_share;
    t_count           r_firings;
    logic [LAT-1:0]   r_vld;
    logic             accept;

    t_count           in_count   [LANES];
    t_count           lane_count [LANES];
    logic [LANES-1:0] lane_blame;
    t_lane_ctl        lane_ctl;
    t_count           sum_s2;
    t_flags           flags;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_sum <= MIN_SUM_RST;
            r_share   <= SHARE_RST;
            r_firings <= FIRINGS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_SUM: r_min_sum <= i_cfg_data;
                CFG_SHARE:   r_share   <= i_cfg_data;
                CFG_FIRINGS: r_firings <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    assign in_count[0] = i_count_cyl0;
    assign in_count[1] = i_count_cyl1;
    assign in_count[2] = i_count_cyl2;
    assign in_count[3] = i_count_cyl3;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        mebe_lane u_lane (
            .i_clk    (i_clk),
            .i_count  (in_count[i]),
            .i_cut    (i_cut_mask[i]),
            .i_fitted (i < FITTED),
            .i_ctl    (lane_ctl),
            .o_count  (lane_count[i]),
            .o_blame  (lane_blame[i])
        );
    end

    mebe_merge u_merge (
        .i_clk     (i_clk),
        .i_count   (lane_count),
        .i_blame   (lane_blame),
        .i_min_sum (r_min_sum),
        .i_share   (r_share),
        .o_sum_s2  (sum_s2),
        .o_ctl     (lane_ctl),
        .o_flags   (flags)
    );

    mebe_rate u_rate (
        .i_clk      (i_clk),
        .i_sum      (sum_s2),
        .i_firings  (r_firings),
        .o_rate     (o_misfire_rate),
        .o_permille (o_rate_permille)
    );

    assign o_done           = r_vld[LAT-1];
    assign o_misfire_sum    = flags.sum;
    assign o_fault_detected = flags.fault;
    assign o_blame_cyl0     = flags.blame[0];
    assign o_blame_cyl1     = flags.blame[1];
    assign o_blame_cyl2     = flags.blame[2];
    assign o_blame_cyl3     = flags.blame[3];
    assign o_blame_none     = flags.none;

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |-> ##12 o_done)
        else $error("result strobe missing for a started item");

    a_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_fault_detected |-> !(o_blame_cyl0 || o_blame_cyl1 ||
                                          o_blame_cyl2 || o_blame_cyl3 || o_blame_none))
        else $error("blame flags set without a fault");

    a_none_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_blame_none |-> !(o_blame_cyl0 || o_blame_cyl1 ||
                                     o_blame_cyl2 || o_blame_cyl3))
        else $error("no-cylinder flag together with a blamed cylinder");

    a_rate_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_misfire_sum >= r_firings) |-> o_misfire_rate == RATE_MAX)
        else $error("misfire rate not saturated");

endmodule
